FILE: src/vcbc_pkg.sv
package vcbc_pkg;

  // function codes of an input word
  localparam logic [1:0] FUNC_POINT = 2'd0;
  localparam logic [1:0] FUNC_ALL   = 2'd1;
  localparam logic [1:0] FUNC_ANY   = 2'd2;
  localparam logic [1:0] FUNC_NONE  = 2'd3;

  // register indexes
  localparam logic [2:0] REG_APEX_X = 3'd0;
  localparam logic [2:0] REG_APEX_Y = 3'd1;
  localparam logic [2:0] REG_APEX_Z = 3'd2;
  localparam logic [2:0] REG_AXIS_X = 3'd3;
  localparam logic [2:0] REG_AXIS_Y = 3'd4;
  localparam logic [2:0] REG_AXIS_Z = 3'd5;
  localparam logic [2:0] REG_COS    = 3'd6;
  localparam logic [2:0] REG_REACH  = 3'd7;

  localparam int ADDR_W = 5;
  localparam int LAST_CORNER = 7;

  typedef struct packed {
    logic signed [31:0] apex_x;
    logic signed [31:0] apex_y;
    logic signed [31:0] apex_z;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic signed [15:0] cos_half_angle;
    logic [30:0]        reach;
  } cfg_t;

  // tags that travel with a corner through the pipe
  typedef struct packed {
    logic [1:0] func;
    logic       first;
    logic       last;
  } tag_t;

  typedef struct packed {
    tag_t               tag;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } corner_t;

endpackage

FILE: src/vcbc_regs.sv
module vcbc_regs
  import vcbc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.apex_x         <= '0;
      cfg.apex_y         <= '0;
      cfg.apex_z         <= '0;
      cfg.axis_x         <= '0;
      cfg.axis_y         <= '0;
      cfg.axis_z         <= 16'sd16384;
      cfg.cos_half_angle <= 16'sd11585;
      cfg.reach          <= 31'd65536000;
    end else if (wr) begin
      case (idx)
        REG_APEX_X: cfg.apex_x         <= pwdata;
        REG_APEX_Y: cfg.apex_y         <= pwdata;
        REG_APEX_Z: cfg.apex_z         <= pwdata;
        REG_AXIS_X: cfg.axis_x         <= pwdata[15:0];
        REG_AXIS_Y: cfg.axis_y         <= pwdata[15:0];
        REG_AXIS_Z: cfg.axis_z         <= pwdata[15:0];
        REG_COS:    cfg.cos_half_angle <= pwdata[15:0];
        REG_REACH:  cfg.reach          <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (idx)
      REG_APEX_X: prdata = cfg.apex_x;
      REG_APEX_Y: prdata = cfg.apex_y;
      REG_APEX_Z: prdata = cfg.apex_z;
      REG_AXIS_X: prdata = {16'd0, cfg.axis_x};
      REG_AXIS_Y: prdata = {16'd0, cfg.axis_y};
      REG_AXIS_Z: prdata = {16'd0, cfg.axis_z};
      REG_COS:    prdata = {16'd0, cfg.cos_half_angle};
      REG_REACH:  prdata = {1'b0, cfg.reach};
      default:    prdata = '0;
    endcase
  end

endmodule

FILE: src/vcbc_seq.sv
module vcbc_seq
  import vcbc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [1:0]         func,
  input  logic signed [31:0] min_x,
  input  logic signed [31:0] min_y,
  input  logic signed [31:0] min_z,
  input  logic signed [31:0] max_x,
  input  logic signed [31:0] max_y,
  input  logic signed [31:0] max_z,
  output logic               crn_valid,
  output corner_t            crn
);

  logic               busy;
  logic [2:0]         cnt;
  logic [1:0]         h_func;
  logic signed [31:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
  logic               last_issue;
  logic               take;
  logic               single;

  assign single     = (h_func == FUNC_POINT) || (h_func == FUNC_NONE);
  assign last_issue = busy && (single || cnt == 3'(LAST_CORNER));
  assign req_stall  = !(advance && (!busy || last_issue));
  assign take       = req_valid && !req_stall;

  // control: one corner per advancing cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      cnt       <= '0;
      crn_valid <= 1'b0;
    end else if (advance) begin
      crn_valid <= busy;
      if (take) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (last_issue) busy <= 1'b0;
      end
    end
  end

  // word hold and corner selection
  always_ff @(posedge clk) begin
    if (take) begin
      h_func <= func;
      lo_x <= min_x; lo_y <= min_y; lo_z <= min_z;
      hi_x <= max_x; hi_y <= max_y; hi_z <= max_z;
    end
    if (advance) begin
      crn.tag.func  <= h_func;
      crn.tag.first <= (cnt == 3'd0);
      crn.tag.last  <= last_issue;
      crn.x <= cnt[0] ? hi_x : lo_x;
      crn.y <= cnt[1] ? hi_y : lo_y;
      crn.z <= cnt[2] ? hi_z : lo_z;
    end
  end

endmodule

FILE: src/vcbc_corner.sv
module vcbc_corner
  import vcbc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    advance,
  input  cfg_t    cfg,
  input  logic    crn_valid,
  input  corner_t crn,
  output logic    hit_valid,
  output tag_t    hit_tag,
  output logic    hit
);

  // stage A: offset from apex
  logic               a_v;
  tag_t               a_tag;
  logic signed [32:0] a_tx, a_ty, a_tz;
  logic               a_zero, a_cneg;
  logic [30:0]        a_c2;
  logic [15:0]        cmag;
  logic signed [32:0] tx, ty, tz;

  // stage B: products
  logic               b_v;
  tag_t               b_tag;
  logic               b_zero, b_cneg;
  logic [30:0]        b_c2;
  logic signed [48:0] b_px, b_py, b_pz;
  logic [65:0]        b_sx, b_sy, b_sz;
  logic [32:0]        mx, my, mz;

  // stage C: sums
  logic               c_v;
  tag_t               c_tag;
  logic               c_zero, c_cneg;
  logic [30:0]        c_c2;
  logic signed [50:0] c_d;
  logic [67:0]        c_len2;

  // stage D: partial products of both squares
  logic               d_v;
  tag_t               d_tag;
  logic               d_zero, d_cneg, d_far, d_pos, d_nneg;
  logic [49:0]        d_hh, d_hl, d_ll;
  logic [53:0]        d_r0, d_r1, d_r2;
  logic [49:0]        dmag;
  logic [68:0]        len2x;

  // stage E: full squares
  logic               e_v;
  tag_t               e_tag;
  logic               e_zero, e_cneg, e_far, e_pos, e_nneg;
  logic [99:0]        e_lhs, e_rhs;

  assign cmag = cfg.cos_half_angle[15] ? 16'(-cfg.cos_half_angle) : cfg.cos_half_angle;
  assign tx = 33'(crn.x) - 33'(cfg.apex_x);
  assign ty = 33'(crn.y) - 33'(cfg.apex_y);
  assign tz = 33'(crn.z) - 33'(cfg.apex_z);

  assign mx = a_tx[32] ? 33'(-a_tx) : a_tx;
  assign my = a_ty[32] ? 33'(-a_ty) : a_ty;
  assign mz = a_tz[32] ? 33'(-a_tz) : a_tz;

  assign dmag  = c_d[50] ? 50'(-c_d) : c_d[49:0];
  assign len2x = {1'b0, c_len2};

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0; b_v <= 1'b0; c_v <= 1'b0;
      d_v <= 1'b0; e_v <= 1'b0; hit_valid <= 1'b0;
    end else if (advance) begin
      a_v <= crn_valid; b_v <= a_v; c_v <= b_v;
      d_v <= c_v; e_v <= d_v; hit_valid <= e_v;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (advance) begin
      a_tag  <= crn.tag;
      a_tx   <= tx; a_ty <= ty; a_tz <= tz;
      a_zero <= (tx == '0) && (ty == '0) && (tz == '0);
      a_cneg <= cfg.cos_half_angle[15];
      a_c2   <= 31'(cmag * cmag);

      b_tag  <= a_tag; b_zero <= a_zero; b_cneg <= a_cneg; b_c2 <= a_c2;
      b_px   <= 49'(a_tx) * 49'(cfg.axis_x);
      b_py   <= 49'(a_ty) * 49'(cfg.axis_y);
      b_pz   <= 49'(a_tz) * 49'(cfg.axis_z);
      b_sx   <= mx * mx;
      b_sy   <= my * my;
      b_sz   <= mz * mz;

      c_tag  <= b_tag; c_zero <= b_zero; c_cneg <= b_cneg; c_c2 <= b_c2;
      c_d    <= 51'(b_px) + 51'(b_py) + 51'(b_pz);
      c_len2 <= 68'(b_sx) + 68'(b_sy) + 68'(b_sz);

      d_tag  <= c_tag; d_zero <= c_zero; d_cneg <= c_cneg;
      d_far  <= c_d >= $signed({6'd0, cfg.reach, 14'd0});
      d_pos  <= !c_d[50] && (c_d != '0);
      d_nneg <= !c_d[50];
      d_hh   <= dmag[49:25] * dmag[49:25];
      d_hl   <= dmag[49:25] * dmag[24:0];
      d_ll   <= dmag[24:0] * dmag[24:0];
      d_r0   <= len2x[22:0] * c_c2;
      d_r1   <= len2x[45:23] * c_c2;
      d_r2   <= len2x[68:46] * c_c2;

      e_tag  <= d_tag; e_zero <= d_zero; e_cneg <= d_cneg;
      e_far  <= d_far; e_pos <= d_pos; e_nneg <= d_nneg;
      e_lhs  <= (100'(d_hh) << 50) + (100'(d_hl) << 26) + 100'(d_ll);
      e_rhs  <= (100'(d_r2) << 46) + (100'(d_r1) << 23) + 100'(d_r0);

      // cone test
      hit_tag <= e_tag;
      if (e_zero || e_far) hit <= 1'b0;
      else if (!e_cneg)    hit <= e_pos && (e_lhs > e_rhs);
      else                 hit <= e_nneg || (e_lhs < e_rhs);
    end
  end

endmodule

FILE: src/vcbc_accum.sv
module vcbc_accum
  import vcbc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  output logic advance,
  input  logic hit_valid,
  input  tag_t hit_tag,
  input  logic hit,
  output logic rsp_valid,
  input  logic rsp_stall,
  output logic verdict
);

  logic acc_all, acc_any;
  logic all_next, any_next;
  logic result;

  assign advance  = !rsp_valid || !rsp_stall;
  assign all_next = hit_tag.first ? hit : (acc_all && hit);
  assign any_next = hit_tag.first ? hit : (acc_any || hit);

  always_comb begin
    case (hit_tag.func)
      FUNC_POINT: result = hit;
      FUNC_ALL:   result = all_next;
      FUNC_ANY:   result = any_next;
      default:    result = 1'b0;
    endcase
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= hit_valid && hit_tag.last;
    end
  end

  // per-box fold over the corners
  always_ff @(posedge clk) begin
    if (advance && hit_valid) begin
      acc_all <= all_next;
      acc_any <= any_next;
      if (hit_tag.last) verdict <= result;
    end
  end

endmodule

FILE: src/view_cone_box_cull_core.sv
// channel | signals                               | direction
// req     | req_valid, req_stall, func, min_*, max_* | in
// rsp     | rsp_valid, rsp_stall, verdict          | out
// apb     | psel, penable, pwrite, paddr, pwdata, prdata, pready | config
//
// A point word (func 0 or 3) issues a single corner; a box word issues eight corners,
// one corner per cycle while the pipe advances, set by the corner sequencer feeding a single test pipe.
// Synchronous reset clears the valid bits; config registers return to their defaults.
// A stall on rsp freezes the whole pipe; req_stall rises while a box is issuing.
module view_cone_box_cull_core
  import vcbc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [1:0]         func,
  input  logic signed [31:0] min_x,
  input  logic signed [31:0] min_y,
  input  logic signed [31:0] min_z,
  input  logic signed [31:0] max_x,
  input  logic signed [31:0] max_y,
  input  logic signed [31:0] max_z,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic               verdict,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t    cfg;
  logic    advance;
  logic    crn_valid;
  corner_t crn;
  logic    hit_valid;
  tag_t    hit_tag;
  logic    hit;

  vcbc_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  vcbc_seq u_seq (
    .clk, .rst, .advance, .req_valid, .req_stall, .func,
    .min_x, .min_y, .min_z, .max_x, .max_y, .max_z, .crn_valid, .crn
  );

  vcbc_corner u_corner (
    .clk, .rst, .advance, .cfg, .crn_valid, .crn, .hit_valid, .hit_tag, .hit
  );

  vcbc_accum u_accum (
    .clk, .rst, .advance, .hit_valid, .hit_tag, .hit, .rsp_valid, .rsp_stall, .verdict
  );

endmodule

FILE: tb/view_cone_box_cull_checker.sv
module view_cone_box_cull_checker
  import vcbc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic               req_stall,
  input  logic [1:0]         func,
  input  logic signed [31:0] min_x,
  input  logic signed [31:0] min_y,
  input  logic signed [31:0] min_z,
  input  logic signed [31:0] max_x,
  input  logic signed [31:0] max_y,
  input  logic signed [31:0] max_z,
  input  logic               rsp_valid,
  input  logic               rsp_stall,
  input  logic               verdict,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t cone;
  bit   verdicts_due[$];

  // exact cone membership of one point
  function automatic bit in_cone(logic signed [31:0] px, logic signed [31:0] py,
                                 logic signed [31:0] pz);
    logic signed [63:0]  tx, ty, tz, d, c;
    logic signed [129:0] len2, lhs, rhs, c2;
    tx = px - cone.apex_x;
    ty = py - cone.apex_y;
    tz = pz - cone.apex_z;
    d  = tx * cone.axis_x + ty * cone.axis_y + tz * cone.axis_z;
    c  = cone.cos_half_angle;
    len2 = tx * tx + ty * ty + tz * tz;
    if (len2 == 0) return 1'b0;
    if (d >= ($signed({33'd0, cone.reach}) <<< 14)) return 1'b0;
    c2  = c * c;
    rhs = len2 * c2;
    lhs = d * d;
    if (c >= 0) return d > 0 && lhs > rhs;
    return d >= 0 || lhs < rhs;
  endfunction

  function automatic bit cull_verdict();
    int hits;
    hits = 0;
    if (func == FUNC_POINT) return in_cone(min_x, min_y, min_z);
    if (func == FUNC_NONE) return 1'b0;
    for (int k = 0; k < 8; k++)
      hits += in_cone(k[0] ? max_x : min_x, k[1] ? max_y : min_y, k[2] ? max_z : min_z);
    if (func == FUNC_ALL) return hits == 8;
    return hits > 0;
  endfunction

  assign pending = verdicts_due.size();

  // track registers, predict accepted words, compare verdicts
  always @(posedge clk) begin
    if (rst) begin
      cone <= '{32'sd0, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd11585,
                31'd65536000};
      verdicts_due.delete();
      fail_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_APEX_X: cone.apex_x <= pwdata;
          REG_APEX_Y: cone.apex_y <= pwdata;
          REG_APEX_Z: cone.apex_z <= pwdata;
          REG_AXIS_X: cone.axis_x <= pwdata[15:0];
          REG_AXIS_Y: cone.axis_y <= pwdata[15:0];
          REG_AXIS_Z: cone.axis_z <= pwdata[15:0];
          REG_COS:    cone.cos_half_angle <= pwdata[15:0];
          REG_REACH:  cone.reach <= pwdata[30:0];
          default: ;
        endcase
      end
      if (req_valid && !req_stall) verdicts_due.push_back(cull_verdict());
      if (rsp_valid && !rsp_stall) begin
        if (verdicts_due.size() == 0) begin
          $error("verdict word with none expected: actual %0b", verdict);
          fail_count <= fail_count + 1;
        end else begin
          bit want;
          want = verdicts_due.pop_front();
          if (verdict !== want) begin
            $error("verdict: expected %0b, actual %0b", want, verdict);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

FILE: tb/tb_view_cone_box_cull_core.sv
module tb_view_cone_box_cull_core;
  timeunit 1ns;
  timeprecision 1ps;
  import vcbc_pkg::*;

  logic clk = 1'b0, rst = 1'b1;
  logic req_valid = 1'b0, req_stall, rsp_valid, rsp_stall = 1'b0, verdict;
  logic [1:0] func = FUNC_POINT;
  logic signed [31:0] min_x = 0, min_y = 0, min_z = 0, max_x = 0, max_y = 0, max_z = 0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0, pready;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  int fail_count, pending;
  int cycles = 0;
  bit quiet = 1'b0, hold_rsp = 1'b0;

  always #10 clk = ~clk;

  view_cone_box_cull_core DUT (.*);
  view_cone_box_cull_checker u_checker (.*);

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver stalls in bursts, plus one long hold
  initial begin
    int n;
    @(negedge rst);
    forever begin
      if (hold_rsp) begin
        rsp_stall <= 1'b1;
        repeat (200) @(posedge clk);
        hold_rsp = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 10);
        rsp_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end else begin
        rsp_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_pipe();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic send_word(logic [1:0] f, logic [31:0] ax, ay, az, bx, by, bz);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    req_valid <= 1'b1;
    func <= f; min_x <= ax; min_y <= ay; min_z <= az;
    max_x <= bx; max_y <= by; max_z <= bz;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  function automatic logic [31:0] wild();
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // a coordinate near the apex, so that cone tests go either way
  function automatic logic [31:0] near(logic [31:0] base);
    return base + $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
  endfunction

  task automatic random_box(logic [31:0] ox, oy, oz);
    logic [1:0] f;
    logic [31:0] ax, ay, az;
    f = $urandom_range(0, 9) == 0 ? FUNC_NONE : 2'($urandom_range(0, 2));
    if ($urandom_range(0, 9) == 0) begin
      send_word(f, wild(), wild(), wild(), wild(), wild(), wild());
    end else begin
      ax = near(ox); ay = near(oy); az = near(oz) + 32'h0010_0000;
      send_word(f, ax, ay, az, ax + $urandom_range(0, 32'h0020_0000),
                ay + $urandom_range(0, 32'h0020_0000), az + $urandom_range(0, 32'h0020_0000));
    end
  endtask

  initial begin
    logic [31:0] ox, oy, oz;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed words at reset settings
    send_word(FUNC_POINT, 0, 0, 0, 0, 0, 0);
    send_word(FUNC_POINT, 0, 0, 32'h0001_0000, 0, 0, 0);
    send_word(FUNC_POINT, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0);
    send_word(FUNC_POINT, 0, 0, 32'h03e8_0000, 0, 0, 0);
    send_word(FUNC_POINT, 0, 0, 32'h03e7_ffff, 0, 0, 0);
    send_word(FUNC_ALL, -32'sh0001_0000, -32'sh0001_0000, 32'h0010_0000,
              32'h0001_0000, 32'h0001_0000, 32'h0020_0000);
    send_word(FUNC_ANY, -32'sh0001_0000, -32'sh0001_0000, 32'h0010_0000,
              32'h0001_0000, 32'h0001_0000, 32'h0020_0000);
    send_word(FUNC_ALL, 32'h0001_0000, 32'h0001_0000, 32'h0020_0000,
              -32'sh0001_0000, -32'sh0001_0000, 32'h0010_0000);
    send_word(FUNC_ANY, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_word(FUNC_ALL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_word(FUNC_NONE, 0, 0, 32'h0001_0000, 0, 0, 32'h0001_0000);
    send_word(FUNC_ANY, 0, 0, 0, 0, 0, 0);
    req_valid <= 1'b0;
    drain_pipe();

    // extreme registers: far apex, negative and oversized cosine, non-unit axis
    write_reg(REG_APEX_X, 32'h8000_0000);
    write_reg(REG_APEX_Y, 32'h7fff_ffff);
    write_reg(REG_APEX_Z, 32'h8000_0000);
    write_reg(REG_AXIS_X, 32'h0000_4000);
    write_reg(REG_AXIS_Y, 32'hffff_c000);
    write_reg(REG_AXIS_Z, 32'h0000_4000);
    write_reg(REG_COS, 32'hffff_c000);
    write_reg(REG_REACH, 32'h7fff_ffff);
    send_word(FUNC_POINT, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0);
    send_word(FUNC_POINT, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0);
    send_word(FUNC_ANY, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    req_valid <= 1'b0;
    drain_pipe();
    write_reg(REG_COS, 32'h0000_4000);
    send_word(FUNC_ALL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    req_valid <= 1'b0;
    drain_pipe();
    write_reg(REG_COS, 32'h0000_7fff);
    send_word(FUNC_POINT, 0, 0, 0, 0, 0, 0);
    req_valid <= 1'b0;
    drain_pipe();
    write_reg(REG_REACH, 32'h0000_0000);
    send_word(FUNC_ANY, 0, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    req_valid <= 1'b0;
    drain_pipe();

    // random phases, each with its own cone
    for (int ph = 0; ph < 6; ph++) begin
      ox = $urandom_range(0, 3) == 0 ? wild() : 32'($signed($urandom_range(0, 32'h0100_0000))
                                                 - 32'sh0080_0000);
      oy = $urandom; oy = $signed(oy) >>> 8;
      oz = $urandom; oz = $signed(oz) >>> 8;
      write_reg(REG_APEX_X, ox);
      write_reg(REG_APEX_Y, oy);
      write_reg(REG_APEX_Z, oz);
      write_reg(REG_AXIS_X, ph == 5 ? 32'($signed(-16384)) : $urandom_range(0, 4000));
      write_reg(REG_AXIS_Y, 32'($signed($urandom_range(0, 8000)) - 4000));
      write_reg(REG_AXIS_Z, ph == 4 ? 32'd16384 : $urandom_range(12000, 16384));
      write_reg(REG_COS, ph == 3 ? 32'($signed(-5000)) : $urandom_range(0, 16384));
      write_reg(REG_REACH, ph == 2 ? 32'h0008_0000 : $urandom_range(0, 32'h7fff_ffff));
      if (ph == 5) quiet = 1'b1;
      for (int i = 0; i < 80; i++) begin
        if (ph == 1 && i == 10) hold_rsp = 1'b1;
        if (ph == 2 && i == 40) begin
          req_valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
        random_box(ox, oy, oz);
      end
      req_valid <= 1'b0;
      drain_pipe();
    end

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
